/* rtl/oled_controller_i2c_target_macros.svh */
// assertion helpers for the display controller target
`ifndef OLED_CONTROLLER_I2C_TARGET_MACROS_SVH
`define OLED_CONTROLLER_I2C_TARGET_MACROS_SVH
`define OCT_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define OCT_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* rtl/oct_pkg.sv */
package oct_pkg;
	localparam int COLUMNS_DEF   = 128;
	localparam int PAGES_DEF     = 8;
	localparam int CMD_BYTES_DEF = 7;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_RESTART = 3'd1,
		OP_STOP    = 3'd2,
		OP_BYTE    = 3'd3,
		OP_RD_FB   = 3'd4,
		OP_RD_SET  = 3'd5,
		OP_NONE6   = 3'd6,
		OP_NONE7   = 3'd7
	} opcode_t;

	localparam logic [0:0] CFG_ADDR    = 1'd0;
	localparam logic [0:0] CFG_PRESENT = 1'd1;

	typedef enum logic [1:0] {
		AM_HORZ = 2'd0,
		AM_VERT = 2'd1,
		AM_PAGE = 2'd2,
		AM_PAGE3 = 2'd3
	} addr_mode_t;

	typedef struct packed {
		opcode_t    op;
		logic [7:0] bus_byte;
		logic [2:0] query_page;
		logic [6:0] query_column;
		logic [3:0] setting_index;
	} req_t;

	typedef struct packed {
		logic        ack;
		logic [7:0]  read_data;
		logic        display_enabled;
		logic        pump_enabled;
		logic        pump_order_fault;
		logic [15:0] unknown_command_count;
		logic [15:0] bad_control_count;
		logic [15:0] early_data_count;
	} rsp_t;

	function automatic logic [2:0] cmd_byte_count(input logic [7:0] c);
		logic [2:0] n;
		n = 3'd1;
		unique case (c)
			8'h20, 8'h81, 8'h8d, 8'ha8, 8'hd3, 8'hd5, 8'hd9, 8'hda, 8'hdb, 8'had, 8'hd8:
				n = 3'd2;
			8'h21, 8'h22, 8'ha3: n = 3'd3;
			8'h29, 8'h2a: n = 3'd6;
			8'h26, 8'h27: n = 3'd7;
			default: n = 3'd1;
		endcase
		return n;
	endfunction
endpackage

/* rtl/oct_stream_if.sv */
interface oct_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/oct_front.sv */
// accepts requests and pushes them into a two entry queue
module oct_front import oct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  req_t      in_req,
	output logic      q_valid,
	input  logic      q_pop,
	output req_t      q_req
);
	req_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

/* rtl/oct_back.sv */
// executes one request per cycle unless stalled by the output or the clearing pass, framebuffer read data registered
module oct_back import oct_pkg::*; #(
	parameter int COLUMNS   = COLUMNS_DEF,
	parameter int PAGES     = PAGES_DEF,
	parameter int CMD_BYTES = CMD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] target_address,
	input  logic       device_present,
	input  logic       q_valid,
	output logic       q_pop,
	input  req_t       q_req,
	output logic       out_valid,
	input  logic       out_ready,
	output rsp_t       out_rsp
);
	localparam int CW = $clog2(COLUMNS);
	localparam int PW = $clog2(PAGES);
	localparam int AW = CW + PW;
	localparam int DEPTH = COLUMNS * PAGES;

	logic [7:0] fb_q [DEPTH];
	// zeroing pass over the framebuffer after reset, one entry per cycle
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic first_q, sel_q, ctl_q, strm_q, dsel_q;
	logic [7:0] cbuf_q [CMD_BYTES];
	logic [2:0] fill_q, need_q;
	logic [1:0] mode_q;
	logic [6:0] wcs_q, wce_q;
	logic [2:0] wps_q, wpe_q;
	logic [7:0] col_q;
	logic [2:0] pg_q;
	logic [7:0] ps_q [8];
	logic [6:0] sf_q;
	logic [15:0] unk_q, bad_q, early_q;

	// output stage
	logic       v_s1;
	logic       fbrd_s1, fbok_s1;
	logic [7:0] fbd_s1;
	rsp_t       r_s1;

	logic stall;
	assign stall = v_s1 && !out_ready;
	assign q_pop = q_valid && !stall && !clr_busy_q;

	// next state
	logic n_first, n_sel, n_ctl, n_strm, n_dsel;
	logic [7:0] n_cbuf [CMD_BYTES];
	logic [2:0] n_fill, n_need;
	logic [1:0] n_mode;
	logic [6:0] n_wcs, n_wce;
	logic [2:0] n_wps, n_wpe;
	logic [7:0] n_col;
	logic [2:0] n_pg;
	logic [7:0] n_ps [8];
	logic [6:0] n_sf;
	logic [15:0] n_unk, n_bad, n_early;
	logic ack, wr_en, rd_ok;
	logic [7:0] rdat, b, op;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] a1, a2;

	assign b = q_req.bus_byte;

	always_comb begin
		n_first = first_q; n_sel = sel_q; n_ctl = ctl_q; n_strm = strm_q; n_dsel = dsel_q;
		n_cbuf = cbuf_q; n_fill = fill_q; n_need = need_q; n_mode = mode_q;
		n_wcs = wcs_q; n_wce = wce_q; n_wps = wps_q; n_wpe = wpe_q;
		n_col = col_q; n_pg = pg_q; n_ps = ps_q; n_sf = sf_q;
		n_unk = unk_q; n_bad = bad_q; n_early = early_q;
		ack = 1'b0; wr_en = 1'b0; rdat = 8'd0; op = 8'd0; a1 = 8'd0; a2 = 8'd0;
		waddr = {pg_q[PW-1:0], col_q[CW-1:0]};
		raddr = {q_req.query_page[PW-1:0], q_req.query_column[CW-1:0]};
		rd_ok = (32'(q_req.query_page) < PAGES) && (32'(q_req.query_column) < COLUMNS);
		unique case (q_req.op)
			OP_START, OP_RESTART: begin
				n_first = 1'b1; n_sel = 1'b0; n_fill = 3'd0; n_need = 3'd0;
			end
			OP_STOP: begin
				n_first = 1'b1; n_sel = 1'b0;
			end
			OP_BYTE: begin
				if (first_q) begin
					ack = device_present && b[7:1] == target_address && !b[0];
					n_first = 1'b0; n_sel = ack; n_ctl = 1'b1; n_strm = 1'b0;
				end else if (sel_q) begin
					ack = 1'b1;
					if (ctl_q) begin
						if (b[5:0] != 6'd0 && bad_q != 16'hffff) n_bad = bad_q + 16'd1;
						n_strm = !b[7]; n_dsel = b[6]; n_ctl = 1'b0;
					end else begin
						if (dsel_q) begin
							wr_en = (32'(col_q[6:0]) < COLUMNS) && (32'(pg_q) < PAGES);
							if (!sf_q[4] && early_q != 16'hffff) n_early = early_q + 16'd1;
							priority case (mode_q)
								AM_HORZ: begin
									if (col_q >= {1'b0, wce_q}) begin
										n_col = {1'b0, wcs_q};
										n_pg = (pg_q >= wpe_q) ? wps_q : pg_q + 3'd1;
									end else n_col = col_q + 8'd1;
								end
								AM_VERT: begin
									if (pg_q >= wpe_q) begin
										n_pg = wps_q;
										n_col = (col_q >= {1'b0, wce_q}) ? {1'b0, wcs_q}
											: col_q + 8'd1;
									end else n_pg = pg_q + 3'd1;
								end
								default: n_col = (col_q >= {1'b0, wce_q}) ? {1'b0, wcs_q}
									: col_q + 8'd1;
							endcase
						end else begin
							if (need_q == 3'd0) begin
								n_fill = 3'd0; n_need = cmd_byte_count(b);
							end
							if (32'(n_fill) < CMD_BYTES) n_cbuf[n_fill[$clog2(CMD_BYTES)-1:0]] = b;
							n_fill = n_fill + 3'd1;
							if (n_fill == n_need) begin
								op = n_cbuf[0];
								a1 = (CMD_BYTES > 1) ? n_cbuf[1] : 8'd0;
								a2 = (CMD_BYTES > 2) ? n_cbuf[2] : 8'd0;
								n_need = 3'd0; n_fill = 3'd0;
								priority if (op <= 8'h0f) n_col = {col_q[7:4], op[3:0]};
								else if (op <= 8'h1f) n_col = {op[3:0], col_q[3:0]};
								else if (op == 8'h20) n_mode = a1[1:0];
								else if (op == 8'h21) begin
									n_wcs = a1[6:0]; n_wce = a2[6:0]; n_col = {1'b0, a1[6:0]};
								end else if (op == 8'h22) begin
									n_wps = a1[2:0]; n_wpe = a2[2:0]; n_pg = a1[2:0];
								end else if (op >= 8'h40 && op <= 8'h7f) n_ps[0] = {2'b0, op[5:0]};
								else if (op == 8'h81) n_ps[1] = a1;
								else if (op == 8'h8d) n_sf[4] = a1[2];
								else if (op == 8'ha0 || op == 8'ha1) n_sf[0] = op[0];
								else if (op == 8'ha4 || op == 8'ha5) n_sf[1] = op[0];
								else if (op == 8'ha6 || op == 8'ha7) n_sf[2] = op[0];
								else if (op == 8'ha8) n_ps[2] = a1;
								else if (op == 8'hae || op == 8'haf) begin
									n_sf[3] = op[0];
									if (op[0] && !sf_q[4]) n_sf[6] = 1'b1;
								end else if (op >= 8'hb0 && op <= 8'hb7) n_pg = op[2:0];
								else if (op == 8'hc0 || op == 8'hc8) n_sf[5] = op[3];
								else if (op == 8'hd3) n_ps[3] = a1;
								else if (op == 8'hd5) n_ps[4] = a1;
								else if (op == 8'hd9) n_ps[5] = a1;
								else if (op == 8'hda) n_ps[6] = a1;
								else if (op == 8'hdb) n_ps[7] = a1;
								else if (op == 8'he3 || op == 8'h26 || op == 8'h27 ||
									op == 8'h29 || op == 8'h2a || op == 8'h2e ||
									op == 8'h2f || op == 8'ha3 || op == 8'had ||
									op == 8'hd8) n_unk = unk_q;
								else if (unk_q != 16'hffff) n_unk = unk_q + 16'd1;
							end
						end
						if (!strm_q) n_ctl = 1'b1;
					end
				end
			end
			OP_RD_SET: begin
				unique case (q_req.setting_index)
					4'd0: rdat = {6'd0, mode_q};
					4'd1: rdat = {1'b0, wcs_q};
					4'd2: rdat = {1'b0, wce_q};
					4'd3: rdat = {5'd0, wps_q};
					4'd4: rdat = {5'd0, wpe_q};
					4'd5: rdat = col_q;
					4'd6: rdat = {5'd0, pg_q};
					4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14:
						rdat = ps_q[3'(q_req.setting_index - 4'd7)];
					default: rdat = {1'b0, sf_q};
				endcase
			end
			default: ;
		endcase
	end

	logic go, rdfb;
	assign go   = q_pop;
	assign rdfb = q_req.op == OP_RD_FB;

	always_ff @(posedge clk) begin
		if (clr_busy_q) fb_q[clr_addr_q] <= 8'd0;
		else if (go && wr_en) fb_q[waddr] <= b;
		if (go && rdfb) fbd_s1 <= fb_q[raddr];
		if (go) begin
			fbok_s1 <= rd_ok;
			r_s1.ack <= ack;
			r_s1.read_data <= rdat;
			r_s1.display_enabled <= n_sf[3];
			r_s1.pump_enabled <= n_sf[4];
			r_s1.pump_order_fault <= n_sf[6];
			r_s1.unknown_command_count <= n_unk;
			r_s1.bad_control_count <= n_bad;
			r_s1.early_data_count <= n_early;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1; clr_addr_q <= '0;
			v_s1 <= 1'b0; fbrd_s1 <= 1'b0;
			first_q <= 1'b1; sel_q <= 1'b0; ctl_q <= 1'b0; strm_q <= 1'b0; dsel_q <= 1'b0;
			for (int i = 0; i < CMD_BYTES; i++) cbuf_q[i] <= 8'd0;
			fill_q <= 3'd0; need_q <= 3'd0; mode_q <= AM_PAGE;
			wcs_q <= 7'd0; wce_q <= 7'(COLUMNS - 1); wps_q <= 3'd0; wpe_q <= 3'(PAGES - 1);
			col_q <= 8'd0; pg_q <= 3'd0;
			ps_q[0] <= 8'h00; ps_q[1] <= 8'h7f; ps_q[2] <= 8'h3f; ps_q[3] <= 8'h00;
			ps_q[4] <= 8'h80; ps_q[5] <= 8'h22; ps_q[6] <= 8'h12; ps_q[7] <= 8'h20;
			sf_q <= 7'd0; unk_q <= 16'd0; bad_q <= 16'd0; early_q <= 16'd0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
			end
			if (go) begin
				v_s1 <= 1'b1; fbrd_s1 <= rdfb;
				first_q <= n_first; sel_q <= n_sel; ctl_q <= n_ctl; strm_q <= n_strm;
				dsel_q <= n_dsel; cbuf_q <= n_cbuf; fill_q <= n_fill; need_q <= n_need;
				mode_q <= n_mode; wcs_q <= n_wcs; wce_q <= n_wce; wps_q <= n_wps;
				wpe_q <= n_wpe; col_q <= n_col; pg_q <= n_pg; ps_q <= n_ps; sf_q <= n_sf;
				unk_q <= n_unk; bad_q <= n_bad; early_q <= n_early;
			end else if (out_ready) v_s1 <= 1'b0;
		end
	end

	assign out_valid = v_s1;
	always_comb begin
		out_rsp = r_s1;
		if (fbrd_s1) out_rsp.read_data = fbok_s1 ? fbd_s1 : 8'd0;
	end
endmodule

/* rtl/oled_controller_i2c_target.sv */
// Display controller target: one bus event or query per request, one response each.
// Sustained rate is one request per clock while the response side is ready; a request passes
// through the front queue, then the execute stage whose framebuffer read is registered. After
// reset the framebuffer is zeroed by a clearing pass over all COLUMNS*PAGES entries (1024 at
// the defaults); requests wait in the front queue until it is done.
module oled_controller_i2c_target import oct_pkg::*; #(
	parameter int COLUMNS   = COLUMNS_DEF,
	parameter int PAGES     = PAGES_DEF,
	parameter int CMD_BYTES = CMD_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	oct_stream_if.sink       req,
	oct_stream_if.source     rsp,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [6:0]       cfg_data
);
`include "oled_controller_i2c_target_macros.svh"
	logic [6:0] addr_q;
	logic       present_q;
	logic       q_valid, q_pop;
	req_t       q_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 7'd60; present_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADDR: addr_q <= cfg_data;
				CFG_PRESENT: present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	oct_front u_front (
		.clk, .arst_n, .in_valid(req.valid), .in_ready(req.ready), .in_req(req.data),
		.q_valid, .q_pop, .q_req
	);

	oct_back #(.COLUMNS(COLUMNS), .PAGES(PAGES), .CMD_BYTES(CMD_BYTES)) u_back (
		.clk, .arst_n, .target_address(addr_q), .device_present(present_q),
		.q_valid, .q_pop, .q_req, .out_valid(rsp.valid), .out_ready(rsp.ready),
		.out_rsp(rsp.data)
	);

	`OCT_ASSERT_IMP(a_pop_valid, clk, arst_n, q_pop, q_valid)
	`OCT_ASSERT_NXT(a_pop_out, clk, arst_n, q_pop, rsp.valid)
	`OCT_ASSERT_IMP(a_ack_byte, clk, arst_n, rsp.valid && rsp.data.ack, rsp.data.read_data == 8'd0)
endmodule
